FILE: sv/mbrtu_pkg.sv
// mbrtu_pkg: shared constants, types and the bit-serial crc step
// used by the frame engine and its channel interfaces
`default_nettype none

package mbrtu_pkg;

  localparam int BYTE_W        = 8;
  localparam int WORD_W        = 16;
  localparam int REG_COUNT     = 8;
  localparam int REG_IDX_W     = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam int FRAME_BYTES   = 32;
  localparam int FB_ADDR_W     = $clog2(FRAME_BYTES);
  localparam int CNT_W         = $clog2(FRAME_BYTES + 1);
  localparam int MAX_READ_REGS = 8;
  localparam int REPLY_MAX     = 21;
  localparam int RLEN_W        = $clog2(REPLY_MAX + 1);
  localparam int WCNT_W        = $clog2(2 * REG_COUNT + 1);

  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 32;
  localparam int CFG_IDX_W     = CFG_ADDR_W - 2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_OWN = '0;
  localparam logic [BYTE_W-1:0]    OWN_ADDR_RESET = 8'h01;

  localparam logic [BYTE_W-1:0] FN_READ   = 8'h03;
  localparam logic [BYTE_W-1:0] FN_WRITE1 = 8'h06;
  localparam logic [BYTE_W-1:0] FN_WRITEN = 8'd16;

  localparam logic [WORD_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [WORD_W-1:0] CRC_POLY = 16'hA001;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [WORD_W-1:0] word_t;

  function automatic word_t crc_bit(input word_t c, input logic b);
    word_t t;
    t = c ^ {{(WORD_W-1){1'b0}}, b};
    if (t[0]) begin
      crc_bit = (t >> 1) ^ CRC_POLY;
    end else begin
      crc_bit = t >> 1;
    end
  endfunction

endpackage

`default_nettype wire

FILE: sv/mbrtu_if.sv
// mbrtu_rx_if / mbrtu_tx_if: valid/ready channels of the frame engine
// depends on mbrtu_pkg for the byte width
`default_nettype none

interface mbrtu_rx_if;
  logic                          valid;
  logic                          ready;
  logic [mbrtu_pkg::BYTE_W-1:0]  rx_byte;
  logic                          frame_end;
  modport source (output valid, output rx_byte, output frame_end, input ready);
  modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface mbrtu_tx_if;
  logic                          valid;
  logic                          ready;
  logic [mbrtu_pkg::BYTE_W-1:0]  tx_byte;
  logic                          tx_last;
  modport source (output valid, output tx_byte, output tx_last, input ready);
  modport sink   (input valid, input tx_byte, input tx_last, output ready);
endinterface

`default_nettype wire

FILE: sv/mbrtu_ram.sv
// mbrtu_ram: generic single-write, single-read ram with registered read
// no dependencies
`default_nettype none

module mbrtu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: sv/modbus_rtu_slave_frame_engine.sv
// modbus_rtu_slave_frame_engine: modbus rtu slave with a holding-register file
// depends on mbrtu_pkg, mbrtu_rx_if, mbrtu_tx_if and mbrtu_ram
//
// rx channel carries received frame bytes, frame_end set on the last byte of
// a frame. tx channel carries reply bytes, tx_last set on the final byte.
// own_address sits at apb offset 0; pready is always high, write at access.
// each received byte is accepted and then fed through the one-bit-per-cycle
// crc shifter. at frame end a check state decides on the reply; a
// write-multiple request then sweeps the frame buffer through wra and wrd
// for each data byte. each reply byte other than the crc is loaded and then
// fed through the crc shifter, the two crc bytes are only loaded. a frame that
// fails any check (crc, address, function, length, range) gives no reply and
// no write. rx is not ready while a frame is checked or a reply is produced.
// a stalled tx sink holds the reply byte in the output register and the
// engine waits. reset clears control state, sets own_address to 1 and loads
// holding register i with i+1; the frame buffer needs no clearing.
`default_nettype none

module modbus_rtu_slave_frame_engine (
  input  wire logic                                clk,
  input  wire logic                                rst,
  mbrtu_rx_if.sink                                 rx,
  mbrtu_tx_if.source                               tx,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [mbrtu_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire logic [mbrtu_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic      [mbrtu_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                     pready
);

  localparam logic [2:0] S_RX  = 3'd0;
  localparam logic [2:0] S_CRC = 3'd1;
  localparam logic [2:0] S_CHK = 3'd2;
  localparam logic [2:0] S_WRA = 3'd3;
  localparam logic [2:0] S_WRD = 3'd4;
  localparam logic [2:0] S_TX  = 3'd5;
  localparam logic [2:0] S_TXC = 3'd6;

  logic [2:0]                          state;
  mbrtu_pkg::byte_t                    own_address;
  logic [mbrtu_pkg::CNT_W-1:0]         cnt;
  logic                                ovf;
  logic                                fend;
  mbrtu_pkg::word_t                    crc;
  mbrtu_pkg::byte_t                    shreg;
  logic [2:0]                          bitcnt;
  mbrtu_pkg::byte_t                    addr_b;
  mbrtu_pkg::byte_t                    func_b;
  mbrtu_pkg::word_t                    start_w;
  mbrtu_pkg::word_t                    qty_w;
  mbrtu_pkg::byte_t                    bcnt_b;
  logic                                is_read;
  logic [mbrtu_pkg::RLEN_W-1:0]        rlen;
  logic [mbrtu_pkg::RLEN_W-1:0]        k;
  logic [mbrtu_pkg::WCNT_W-1:0]        j;
  mbrtu_pkg::byte_t                    hi_b;
  mbrtu_pkg::word_t                    hregs [mbrtu_pkg::REG_COUNT];

  logic                                tx_valid;
  mbrtu_pkg::byte_t                    tx_data;
  logic                                tx_lst;

  // config port
  logic cfg_we;
  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    if (paddr[mbrtu_pkg::CFG_ADDR_W-1:2] == mbrtu_pkg::CFG_IDX_OWN) begin
      prdata = {{(mbrtu_pkg::CFG_DATA_W-mbrtu_pkg::BYTE_W){1'b0}}, own_address};
    end else begin
      prdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= mbrtu_pkg::OWN_ADDR_RESET;
    end else if (cfg_we && paddr[mbrtu_pkg::CFG_ADDR_W-1:2] == mbrtu_pkg::CFG_IDX_OWN) begin
      own_address <= pwdata[mbrtu_pkg::BYTE_W-1:0];
    end
  end

  // frame buffer
  logic                               rx_xfer;
  logic                               fb_we;
  logic [mbrtu_pkg::FB_ADDR_W-1:0]    fb_raddr;
  mbrtu_pkg::byte_t                   fb_rdata;

  assign rx.ready = (state == S_RX);
  assign rx_xfer  = rx.valid && rx.ready;
  assign fb_we    = rx_xfer && (cnt < mbrtu_pkg::CNT_W'(mbrtu_pkg::FRAME_BYTES));
  assign fb_raddr = mbrtu_pkg::FB_ADDR_W'(j + mbrtu_pkg::WCNT_W'(7));

  mbrtu_ram #(
    .WIDTH (mbrtu_pkg::BYTE_W),
    .DEPTH (mbrtu_pkg::FRAME_BYTES)
  ) u_fbuf (
    .clk   (clk),
    .we    (fb_we),
    .waddr (cnt[mbrtu_pkg::FB_ADDR_W-1:0]),
    .wdata (rx.rx_byte),
    .raddr (fb_raddr),
    .rdata (fb_rdata)
  );

  // frame checks
  logic [mbrtu_pkg::WORD_W:0]   range_end;
  logic [mbrtu_pkg::WORD_W+1:0] f16_len;
  logic                         in_range;
  logic                         base_ok;
  logic                         f3_ok;
  logic                         f6_ok;
  logic                         f16_ok;

  assign range_end = {1'b0, start_w} + {1'b0, qty_w};
  assign f16_len   = {1'b0, qty_w, 1'b0} + (mbrtu_pkg::WORD_W+2)'(9);
  assign in_range  = (qty_w != '0) &&
                     (range_end <= (mbrtu_pkg::WORD_W+1)'(mbrtu_pkg::REG_COUNT));
  assign base_ok   = !ovf && (cnt >= mbrtu_pkg::CNT_W'(8)) && (crc == '0) &&
                     (addr_b != '0) && (addr_b == own_address);
  assign f3_ok     = (func_b == mbrtu_pkg::FN_READ) && (cnt == mbrtu_pkg::CNT_W'(8)) &&
                     in_range &&
                     (qty_w <= mbrtu_pkg::WORD_W'(mbrtu_pkg::MAX_READ_REGS));
  assign f6_ok     = (func_b == mbrtu_pkg::FN_WRITE1) && (cnt == mbrtu_pkg::CNT_W'(8)) &&
                     (start_w < mbrtu_pkg::WORD_W'(mbrtu_pkg::REG_COUNT));
  assign f16_ok    = (func_b == mbrtu_pkg::FN_WRITEN) && in_range &&
                     ({{(mbrtu_pkg::WORD_W+2-mbrtu_pkg::CNT_W){1'b0}}, cnt} == f16_len) &&
                     (bcnt_b == {qty_w[mbrtu_pkg::BYTE_W-2:0], 1'b0});

  // reply byte select
  logic [mbrtu_pkg::RLEN_W-1:0]    d;
  logic [mbrtu_pkg::REG_IDX_W-1:0] rd_idx;
  mbrtu_pkg::word_t                rd_word;
  mbrtu_pkg::byte_t                tx_sel;
  logic                            is_crc;
  logic                            is_last;
  logic                            tx_load;

  assign d       = k - mbrtu_pkg::RLEN_W'(3);
  assign rd_idx  = start_w[mbrtu_pkg::REG_IDX_W-1:0] + mbrtu_pkg::REG_IDX_W'(d[mbrtu_pkg::RLEN_W-1:1]);
  assign rd_word = hregs[rd_idx];
  assign is_crc  = (k >= rlen - mbrtu_pkg::RLEN_W'(2));
  assign is_last = (k == rlen - mbrtu_pkg::RLEN_W'(1));
  assign tx_load = (state == S_TX) && (!tx_valid || tx.ready);

  always_comb begin
    tx_sel = '0;
    if (is_crc) begin
      tx_sel = is_last ? crc[15:8] : crc[7:0];
    end else if (is_read) begin
      case (k)
        5'd0:    tx_sel = addr_b;
        5'd1:    tx_sel = mbrtu_pkg::FN_READ;
        5'd2:    tx_sel = {qty_w[mbrtu_pkg::BYTE_W-2:0], 1'b0};
        default: tx_sel = d[0] ? rd_word[7:0] : rd_word[15:8];
      endcase
    end else begin
      case (k)
        5'd0:    tx_sel = addr_b;
        5'd1:    tx_sel = func_b;
        5'd2:    tx_sel = start_w[15:8];
        5'd3:    tx_sel = start_w[7:0];
        5'd4:    tx_sel = qty_w[15:8];
        5'd5:    tx_sel = qty_w[7:0];
        default: tx_sel = '0;
      endcase
    end
  end

  // holding register write port
  logic                            hr_we;
  logic [mbrtu_pkg::REG_IDX_W-1:0] hr_waddr;
  mbrtu_pkg::word_t                hr_wdata;

  always_comb begin
    hr_we    = 1'b0;
    hr_waddr = start_w[mbrtu_pkg::REG_IDX_W-1:0];
    hr_wdata = qty_w;
    if (state == S_CHK && base_ok && f6_ok) begin
      hr_we = 1'b1;
    end else if (state == S_WRD && j[0]) begin
      hr_we    = 1'b1;
      hr_waddr = start_w[mbrtu_pkg::REG_IDX_W-1:0] +
                 mbrtu_pkg::REG_IDX_W'(j[mbrtu_pkg::WCNT_W-1:1]);
      hr_wdata = {hi_b, fb_rdata};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mbrtu_pkg::REG_COUNT; i++) begin
        hregs[i] <= mbrtu_pkg::WORD_W'(i + 1);
      end
    end else if (hr_we) begin
      hregs[hr_waddr] <= hr_wdata;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_RX;
      cnt      <= '0;
      ovf      <= 1'b0;
      crc      <= mbrtu_pkg::CRC_INIT;
      bitcnt   <= '0;
      k        <= '0;
      j        <= '0;
    end else begin
      case (state)
        S_RX: begin
          if (rx_xfer) begin
            shreg  <= rx.rx_byte;
            fend   <= rx.frame_end;
            bitcnt <= '0;
            state  <= S_CRC;
            if (fb_we) begin
              cnt <= cnt + mbrtu_pkg::CNT_W'(1);
            end else begin
              ovf <= 1'b1;
            end
            case (cnt)
              6'd0:    addr_b         <= rx.rx_byte;
              6'd1:    func_b         <= rx.rx_byte;
              6'd2:    start_w[15:8]  <= rx.rx_byte;
              6'd3:    start_w[7:0]   <= rx.rx_byte;
              6'd4:    qty_w[15:8]    <= rx.rx_byte;
              6'd5:    qty_w[7:0]     <= rx.rx_byte;
              6'd6:    bcnt_b         <= rx.rx_byte;
              default: ;
            endcase
          end
        end
        S_CRC: begin
          crc    <= mbrtu_pkg::crc_bit(crc, shreg[0]);
          shreg  <= shreg >> 1;
          bitcnt <= bitcnt + 3'd1;
          if (bitcnt == 3'd7) begin
            state <= fend ? S_CHK : S_RX;
          end
        end
        S_CHK: begin
          k       <= '0;
          j       <= '0;
          is_read <= f3_ok;
          crc     <= mbrtu_pkg::CRC_INIT;
          rlen    <= f3_ok ? mbrtu_pkg::RLEN_W'(5) + {qty_w[3:0], 1'b0}
                           : mbrtu_pkg::RLEN_W'(8);
          if (base_ok && f16_ok) begin
            state <= S_WRA;
          end else if (base_ok && (f3_ok || f6_ok)) begin
            state <= S_TX;
          end else begin
            state <= S_RX;
            cnt   <= '0;
            ovf   <= 1'b0;
          end
        end
        S_WRA: begin
          state <= S_WRD;
        end
        S_WRD: begin
          hi_b <= fb_rdata;
          j    <= j + mbrtu_pkg::WCNT_W'(1);
          if ((j + mbrtu_pkg::WCNT_W'(1)) == {qty_w[mbrtu_pkg::WCNT_W-2:0], 1'b0}) begin
            state <= S_TX;
          end else begin
            state <= S_WRA;
          end
        end
        S_TX: begin
          if (tx_load) begin
            tx_data  <= tx_sel;
            tx_lst   <= is_last;
            if (!is_crc) begin
              shreg  <= tx_sel;
              bitcnt <= '0;
              state  <= S_TXC;
            end else if (is_last) begin
              state <= S_RX;
              cnt   <= '0;
              ovf   <= 1'b0;
              crc   <= mbrtu_pkg::CRC_INIT;
            end else begin
              k <= k + mbrtu_pkg::RLEN_W'(1);
            end
          end
        end
        S_TXC: begin
          crc    <= mbrtu_pkg::crc_bit(crc, shreg[0]);
          shreg  <= shreg >> 1;
          bitcnt <= bitcnt + 3'd1;
          if (bitcnt == 3'd7) begin
            k     <= k + mbrtu_pkg::RLEN_W'(1);
            state <= S_TX;
          end
        end
        default: begin
          state <= S_RX;
        end
      endcase
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_valid <= 1'b0;
    end else if (tx_load) begin
      tx_valid <= 1'b1;
    end else if (tx.ready) begin
      tx_valid <= 1'b0;
    end
  end

  assign tx.valid   = tx_valid;
  assign tx.tx_byte = tx_data;
  assign tx.tx_last = tx_lst;

  // checks
  a_hr_write_src: assert property (@(posedge clk) disable iff (rst)
    hr_we |-> (state == S_CHK || state == S_WRD))
    else $error("holding register written outside check or sweep");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= mbrtu_pkg::CNT_W'(mbrtu_pkg::FRAME_BYTES))
    else $error("byte count past buffer depth");

  a_rx_to_crc: assert property (@(posedge clk) disable iff (rst)
    rx_xfer |=> state == S_CRC)
    else $error("received byte not followed by crc update");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (tx_load && is_last) |=> (state == S_RX && cnt == '0))
    else $error("final reply byte did not return to receive");

  a_reply_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_TX) |-> (rlen <= mbrtu_pkg::RLEN_W'(mbrtu_pkg::REPLY_MAX) && k < rlen))
    else $error("reply index out of range");

endmodule

`default_nettype wire

FILE: test/tb.sv
// tb: frame-level test of modbus_rtu_slave_frame_engine with random valid/ready pacing
// a scoreboard class models the slave and matches every reply byte in order
// depends on mbrtu_pkg, mbrtu_rx_if, mbrtu_tx_if and the engine rtl

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef mbrtu_pkg::byte_t frame_t[$];

  typedef struct {
    mbrtu_pkg::byte_t data;
    logic             last;
  } reply_beat_t;

  typedef enum int {
    FLAW_BAD_CRC,
    FLAW_FOREIGN,
    FLAW_BROADCAST,
    FLAW_BAD_FUNCTION,
    FLAW_SHORT,
    FLAW_OVERFLOW,
    FLAW_BAD_LENGTH,
    FLAW_BAD_RANGE,
    FLAW_BYTE_COUNT
  } flaw_t;

  localparam int FLAW_KINDS    = 9;
  localparam int LIMIT_CYCLES  = 4000000;
  localparam int LONG_HOLD     = 600;
  localparam int SETTLE_CYCLES = 120;

  class slave_reply_tracker;
    mbrtu_pkg::byte_t rx_store[mbrtu_pkg::FRAME_BYTES];
    int               rx_count;
    bit               rx_overflow;
    mbrtu_pkg::word_t hold_regs[mbrtu_pkg::REG_COUNT];
    mbrtu_pkg::byte_t own_addr;
    reply_beat_t      pending[$];
    int               mismatches;

    function new();
      rx_count    = 0;
      rx_overflow = 1'b0;
      own_addr    = mbrtu_pkg::OWN_ADDR_RESET;
      mismatches  = 0;
      foreach (hold_regs[i]) hold_regs[i] = mbrtu_pkg::word_t'(i + 1);
    endfunction

    static function mbrtu_pkg::word_t crc_of(input frame_t f, input int n);
      mbrtu_pkg::word_t c;
      int               i;
      c = mbrtu_pkg::CRC_INIT;
      for (i = 0; i < n; i++) begin
        c ^= {8'h00, f[i]};
        repeat (8) c = c[0] ? ((c >> 1) ^ mbrtu_pkg::CRC_POLY) : (c >> 1);
      end
      return c;
    endfunction

    function void serve_frame();
      frame_t           reply, body;
      int               n, i;
      mbrtu_pkg::word_t got, start, qty, c;
      n = rx_count;
      if (rx_overflow || n < 4) return;
      for (i = 0; i < n - 2; i++) body.push_back(rx_store[i]);
      got = {rx_store[n-1], rx_store[n-2]};
      if (crc_of(body, n - 2) != got) return;
      if (rx_store[0] == 8'h00 || rx_store[0] != own_addr) return;
      if (n < 8) return;
      start = {rx_store[2], rx_store[3]};
      qty   = {rx_store[4], rx_store[5]};
      case (rx_store[1])
        mbrtu_pkg::FN_READ: begin
          if (n != 8 || qty == 0 || qty > mbrtu_pkg::MAX_READ_REGS ||
              int'(start) + int'(qty) > mbrtu_pkg::REG_COUNT) return;
          reply = {own_addr, mbrtu_pkg::FN_READ, mbrtu_pkg::byte_t'(qty * 2)};
          for (i = 0; i < qty; i++) begin
            reply.push_back(hold_regs[start + i][15:8]);
            reply.push_back(hold_regs[start + i][7:0]);
          end
        end
        mbrtu_pkg::FN_WRITE1: begin
          if (n != 8 || start >= mbrtu_pkg::REG_COUNT) return;
          hold_regs[start] = qty;
          for (i = 0; i < 6; i++) reply.push_back(rx_store[i]);
        end
        mbrtu_pkg::FN_WRITEN: begin
          if (qty == 0 || int'(start) + int'(qty) > mbrtu_pkg::REG_COUNT ||
              n != 9 + 2 * int'(qty) || rx_store[6] != mbrtu_pkg::byte_t'(qty * 2)) return;
          for (i = 0; i < qty; i++)
            hold_regs[start + i] = {rx_store[7 + 2*i], rx_store[8 + 2*i]};
          for (i = 0; i < 6; i++) reply.push_back(rx_store[i]);
        end
        default: return;
      endcase
      c = crc_of(reply, reply.size());
      reply.push_back(c[7:0]);
      reply.push_back(c[15:8]);
      for (i = 0; i < reply.size(); i++)
        pending.push_back('{data: reply[i], last: (i == reply.size() - 1)});
    endfunction

    function void take_rx_byte(input mbrtu_pkg::byte_t b, input logic last);
      if (rx_count < mbrtu_pkg::FRAME_BYTES) begin
        rx_store[rx_count] = b;
        rx_count++;
      end else begin
        rx_overflow = 1'b1;
      end
      if (last) begin
        serve_frame();
        rx_count    = 0;
        rx_overflow = 1'b0;
      end
    endfunction

    task report(input string what);
      $display("mismatch: %s", what);
      mismatches++;
    endtask

    task match_tx_byte(input mbrtu_pkg::byte_t b, input logic last);
      reply_beat_t e;
      if (pending.size() == 0) begin
        report($sformatf("reply byte %02h last %0b with nothing pending", b, last));
        return;
      end
      e = pending.pop_front();
      if (b !== e.data)
        report($sformatf("tx_byte %02h, expected %02h", b, e.data));
      if (last !== e.last)
        report($sformatf("tx_last %0b, expected %0b (byte %02h)", last, e.last, e.data));
    endtask

    task flag_leftovers();
      if (pending.size() != 0)
        report($sformatf("%0d reply bytes never sent", pending.size()));
    endtask
  endclass

  logic                             clk;
  logic                             rst;
  logic                             psel;
  logic                             penable;
  logic                             pwrite;
  logic [mbrtu_pkg::CFG_ADDR_W-1:0] paddr;
  logic [mbrtu_pkg::CFG_DATA_W-1:0] pwdata;
  logic [mbrtu_pkg::CFG_DATA_W-1:0] prdata;
  logic                             pready;

  mbrtu_rx_if rx_ch ();
  mbrtu_tx_if tx_ch ();

  modbus_rtu_slave_frame_engine i_dut (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx_ch),
    .tx      (tx_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  slave_reply_tracker tracker = new();

  int cycles        = 0;
  int bytes_sent    = 0;
  int frame_no      = 0;
  int hold_requests = 0;
  int holds_served  = 0;
  int tx_stall      = 0;
  bit rx_steady     = 1'b0;
  bit tx_steady     = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycles <= cycles + 1;

  initial begin
    wait (cycles >= LIMIT_CYCLES);
    $display("== FAIL ==");
    $finish;
  end

  function automatic int pick_gap(input bit steady);
    int r;
    r = $urandom_range(99);
    if (steady || r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(15, 4);
    return $urandom_range(80, 20);
  endfunction

  // tx ready pacing, long hold on request
  always @(posedge clk) begin : tx_pace
    int g;
    if (rst) begin
      tx_ch.ready <= 1'b0;
      tx_stall    <= 0;
    end else if (holds_served != hold_requests) begin
      holds_served <= hold_requests;
      tx_stall     <= LONG_HOLD;
      tx_ch.ready  <= 1'b0;
    end else if (tx_stall > 0) begin
      tx_stall    <= tx_stall - 1;
      tx_ch.ready <= 1'b0;
    end else begin
      g = pick_gap(tx_steady);
      tx_ch.ready <= (g == 0);
      tx_stall    <= (g > 0) ? g - 1 : 0;
    end
  end

  always @(posedge clk) begin
    if (!rst && tx_ch.valid && tx_ch.ready)
      tracker.match_tx_byte(tx_ch.tx_byte, tx_ch.tx_last);
  end

  function automatic frame_t sealed(input frame_t body);
    mbrtu_pkg::word_t c;
    c = slave_reply_tracker::crc_of(body, body.size());
    body.push_back(c[7:0]);
    body.push_back(c[15:8]);
    return body;
  endfunction

  function automatic frame_t req_head(input mbrtu_pkg::byte_t addr,
                                      input mbrtu_pkg::byte_t fn,
                                      input mbrtu_pkg::word_t st,
                                      input mbrtu_pkg::word_t q);
    frame_t f;
    f = {addr, fn, st[15:8], st[7:0], q[15:8], q[7:0]};
    return f;
  endfunction

  function automatic frame_t good_frame(input mbrtu_pkg::byte_t addr);
    frame_t f;
    int     qty, start, i;
    case ($urandom_range(2))
      0: begin
        qty   = ($urandom_range(3) == 0) ? mbrtu_pkg::MAX_READ_REGS
                                         : $urandom_range(mbrtu_pkg::MAX_READ_REGS, 1);
        start = $urandom_range(mbrtu_pkg::REG_COUNT - qty);
        f = req_head(addr, mbrtu_pkg::FN_READ, mbrtu_pkg::word_t'(start),
                     mbrtu_pkg::word_t'(qty));
      end
      1: begin
        f = req_head(addr, mbrtu_pkg::FN_WRITE1,
                     mbrtu_pkg::word_t'($urandom_range(mbrtu_pkg::REG_COUNT - 1)),
                     mbrtu_pkg::word_t'($urandom));
      end
      default: begin
        qty   = ($urandom_range(3) == 0) ? $urandom_range(mbrtu_pkg::REG_COUNT, 1)
                                         : $urandom_range(3, 1);
        start = $urandom_range(mbrtu_pkg::REG_COUNT - qty);
        f = req_head(addr, mbrtu_pkg::FN_WRITEN, mbrtu_pkg::word_t'(start),
                     mbrtu_pkg::word_t'(qty));
        f.push_back(mbrtu_pkg::byte_t'(2 * qty));
        for (i = 0; i < 2 * qty; i++) f.push_back(mbrtu_pkg::byte_t'($urandom));
      end
    endcase
    return sealed(f);
  endfunction

  function automatic frame_t flawed_frame(input flaw_t kind, input mbrtu_pkg::byte_t own);
    frame_t           f;
    mbrtu_pkg::byte_t a, fn, bc;
    mbrtu_pkg::word_t st, q;
    int               i, n;
    case (kind)
      FLAW_BAD_CRC: begin
        f = good_frame(own);
        i = $urandom_range(f.size() - 1);
        f[i] = f[i] ^ (8'h01 << $urandom_range(7));
      end
      FLAW_FOREIGN: begin
        do a = mbrtu_pkg::byte_t'($urandom_range(255, 1)); while (a == own);
        f = good_frame(a);
      end
      FLAW_BROADCAST: f = good_frame(8'h00);
      FLAW_BAD_FUNCTION: begin
        do fn = mbrtu_pkg::byte_t'($urandom);
        while (fn == mbrtu_pkg::FN_READ || fn == mbrtu_pkg::FN_WRITE1 ||
               fn == mbrtu_pkg::FN_WRITEN);
        f = {own, fn};
        repeat (6) f.push_back(mbrtu_pkg::byte_t'($urandom));
        f = sealed(f);
      end
      FLAW_SHORT: begin
        n = $urandom_range(7, 1);
        if (n < 4) begin
          repeat (n) f.push_back(mbrtu_pkg::byte_t'($urandom));
        end else begin
          f = {own};
          repeat (n - 3) f.push_back(mbrtu_pkg::byte_t'($urandom));
          f = sealed(f);
        end
      end
      FLAW_OVERFLOW: begin
        n = $urandom_range(mbrtu_pkg::FRAME_BYTES + 8, mbrtu_pkg::FRAME_BYTES + 1);
        f = {own, mbrtu_pkg::FN_WRITEN};
        while (f.size() < n - 2) f.push_back(mbrtu_pkg::byte_t'($urandom));
        f = sealed(f);
      end
      FLAW_BAD_LENGTH: begin
        f = good_frame(own);
        void'(f.pop_back());
        void'(f.pop_back());
        if ($urandom_range(1)) f.push_back(mbrtu_pkg::byte_t'($urandom));
        else void'(f.pop_back());
        f = sealed(f);
      end
      FLAW_BAD_RANGE: begin
        case ($urandom_range(5))
          0: f = req_head(own, mbrtu_pkg::FN_READ,
                          mbrtu_pkg::word_t'($urandom_range(mbrtu_pkg::REG_COUNT - 1)),
                          mbrtu_pkg::word_t'(0));
          1: f = req_head(own, mbrtu_pkg::FN_READ,
                          mbrtu_pkg::word_t'($urandom_range(mbrtu_pkg::REG_COUNT - 1)),
                          mbrtu_pkg::word_t'($urandom_range(16'hFFFF,
                                                            mbrtu_pkg::MAX_READ_REGS + 1)));
          2: begin
            q = mbrtu_pkg::word_t'($urandom_range(mbrtu_pkg::MAX_READ_REGS, 1));
            f = req_head(own, mbrtu_pkg::FN_READ,
                         mbrtu_pkg::word_t'($urandom_range(16'hFFFF,
                                                           mbrtu_pkg::REG_COUNT - q + 1)),
                         q);
          end
          3: f = req_head(own, mbrtu_pkg::FN_WRITE1,
                          mbrtu_pkg::word_t'($urandom_range(16'hFFFF, mbrtu_pkg::REG_COUNT)),
                          mbrtu_pkg::word_t'($urandom));
          4: begin
            f = req_head(own, mbrtu_pkg::FN_WRITEN,
                         mbrtu_pkg::word_t'($urandom_range(mbrtu_pkg::REG_COUNT - 1)),
                         mbrtu_pkg::word_t'(0));
            f.push_back(8'h00);
          end
          default: begin
            q  = mbrtu_pkg::word_t'($urandom_range(mbrtu_pkg::REG_COUNT, 1));
            st = mbrtu_pkg::word_t'($urandom_range(mbrtu_pkg::REG_COUNT + 2,
                                                   mbrtu_pkg::REG_COUNT - q + 1));
            f  = req_head(own, mbrtu_pkg::FN_WRITEN, st, q);
            f.push_back(mbrtu_pkg::byte_t'(2 * q));
            repeat (2 * q) f.push_back(mbrtu_pkg::byte_t'($urandom));
          end
        endcase
        f = sealed(f);
      end
      default: begin
        q  = mbrtu_pkg::word_t'($urandom_range(4, 1));
        st = mbrtu_pkg::word_t'($urandom_range(mbrtu_pkg::REG_COUNT - q));
        do bc = mbrtu_pkg::byte_t'($urandom); while (bc == mbrtu_pkg::byte_t'(2 * q));
        f = req_head(own, mbrtu_pkg::FN_WRITEN, st, q);
        f.push_back(bc);
        repeat (2 * q) f.push_back(mbrtu_pkg::byte_t'($urandom));
        f = sealed(f);
      end
    endcase
    return f;
  endfunction

  task automatic send_frame(input frame_t f);
    int i, gap;
    for (i = 0; i < f.size(); i++) begin
      gap = pick_gap(rx_steady);
      if (gap > 0) begin
        rx_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rx_ch.valid     <= 1'b1;
      rx_ch.rx_byte   <= f[i];
      rx_ch.frame_end <= (i == f.size() - 1);
      do @(posedge clk); while (!rx_ch.ready);
      tracker.take_rx_byte(f[i], i == f.size() - 1);
      bytes_sent++;
    end
  endtask

  task automatic run_traffic(input int quota);
    int     goal;
    frame_t f;
    goal = bytes_sent + quota;
    while (bytes_sent < goal) begin
      if (frame_no % 3 == 2)
        f = flawed_frame(flaw_t'((frame_no / 3) % FLAW_KINDS), tracker.own_addr);
      else
        f = good_frame(tracker.own_addr);
      frame_no++;
      send_frame(f);
    end
  endtask

  // no reply pending, then time for a dropped frame to finish its checks
  task automatic settle();
    rx_ch.valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_own_address(input mbrtu_pkg::byte_t a);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {mbrtu_pkg::CFG_IDX_OWN, 2'b00};
    pwdata  <= mbrtu_pkg::CFG_DATA_W'(a);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.own_addr = a;
  endtask

  initial begin
    frame_t lone;
    rst             <= 1'b1;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    rx_ch.valid     <= 1'b0;
    rx_ch.rx_byte   <= '0;
    rx_ch.frame_end <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset register contents, top register to all ones, a lone byte frame
    send_frame(sealed(req_head(mbrtu_pkg::OWN_ADDR_RESET, mbrtu_pkg::FN_READ,
                               mbrtu_pkg::word_t'(0),
                               mbrtu_pkg::word_t'(mbrtu_pkg::MAX_READ_REGS))));
    send_frame(sealed(req_head(mbrtu_pkg::OWN_ADDR_RESET, mbrtu_pkg::FN_WRITE1,
                               mbrtu_pkg::word_t'(mbrtu_pkg::REG_COUNT - 1), 16'hFFFF)));
    lone.push_back(8'hFF);
    send_frame(lone);
    send_frame(sealed(req_head(mbrtu_pkg::OWN_ADDR_RESET, mbrtu_pkg::FN_READ,
                               mbrtu_pkg::word_t'(mbrtu_pkg::REG_COUNT - 1),
                               mbrtu_pkg::word_t'(1))));
    settle();

    write_own_address(8'd247);
    run_traffic(90);
    settle();

    // own address zero: every frame is dropped, the ones sent to it as broadcast
    write_own_address(8'h00);
    run_traffic(25);
    settle();

    write_own_address(mbrtu_pkg::OWN_ADDR_RESET);
    hold_requests <= hold_requests + 1;
    run_traffic(60);
    settle();
    rx_steady = 1'b1;
    tx_steady <= 1'b1;
    run_traffic(40);
    rx_steady = 1'b0;
    tx_steady <= 1'b0;
    settle();

    write_own_address(mbrtu_pkg::byte_t'($urandom_range(246, 2)));
    run_traffic(70);
    settle();

    tracker.flag_leftovers();
    if (tracker.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/mbrtu_pkg.sv
sv/mbrtu_if.sv
sv/mbrtu_ram.sv
sv/modbus_rtu_slave_frame_engine.sv
test/tb.sv
